/* hw/rtl/occupancy_grid_ray_update_core_macros.svh */
// assertion macros for the occupancy grid ray update core
`ifndef OCCUPANCY_GRID_RAY_UPDATE_CORE_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OGRU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ogru assertion failed");
`define OGRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ogru assertion failed");
`else
`define OGRU_ASSERT_IMP(lbl, ante, cons)
`define OGRU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/ogru_pkg.sv */
// shared types and constants for the occupancy grid ray update core
`default_nettype none
package ogru_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;
    localparam int GX_BITS     = 6;
    localparam int GY_BITS     = 6;
    localparam int ADDR_W      = GX_BITS + GY_BITS;
    localparam int ANGLE_BITS  = 12;
    localparam int T_SHIFT     = 16 - (ANGLE_BITS - 2);

    localparam int POS_W  = 14;
    localparam int RAY_W  = 25;
    localparam int LOG_W  = 12;
    localparam int MUL_W  = 22;
    localparam int PROD_W = 2 * MUL_W;
    localparam int STEP_W = 14;

    localparam logic [16:0] POLY_A   = 17'd102944;
    localparam logic [16:0] POLY_B   = 17'd42334;
    localparam logic [16:0] POLY_C   = 17'd5223;
    localparam logic [16:0] Q16_ONE  = 17'd65536;
    localparam logic [16:0] STEP_Q16 = 17'd13107;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_BEAM   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] END_NONE  = 2'd0;
    localparam logic [1:0] END_HIT   = 2'd1;
    localparam logic [1:0] END_LEFT  = 2'd2;
    localparam logic [1:0] END_RANGE = 2'd3;

    localparam logic [2:0] CFG_HIT   = 3'd0;
    localparam logic [2:0] CFG_PASS  = 3'd1;
    localparam logic [2:0] CFG_MIN   = 3'd2;
    localparam logic [2:0] CFG_MAX   = 3'd3;
    localparam logic [2:0] CFG_RANGE = 3'd4;

    localparam logic [9:0]  HIT_RESET   = 10'd217;
    localparam logic [10:0] PASS_RESET  = 11'h727;
    localparam logic [11:0] MIN_RESET   = 12'hD00;
    localparam logic [10:0] MAX_RESET   = 11'd768;
    localparam logic [15:0] RANGE_RESET = 16'd7680;

    typedef enum logic [2:0] {
        MUL_UU  = 3'd0,
        MUL_CT2 = 3'd1,
        MUL_BT2 = 3'd2,
        MUL_AU  = 3'd3,
        MUL_SK  = 3'd4,
        MUL_OX  = 3'd5,
        MUL_OY  = 3'd6,
        MUL_RR  = 3'd7
    } mul_sel_t;

    typedef struct packed {
        logic       take;
        logic       clear;
        logic       world_we;
        logic       rd_ray;
        logic       cap_cval;
        logic       arg_hi;
        mul_sel_t   mul_sel;
        logic       cap_t2;
        logic       cap_da;
        logic       cap_db;
        logic       load_ray;
        logic       step_ray;
        logic       set_end;
        logic       occ_we;
        logic       cap_sq;
        logic       reason_we;
        logic [1:0] reason;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_grid;
        logic hit;
        logic exceeded;
    } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/ogru_ctrl.sv */
// controller state machine for the occupancy grid ray update core
`default_nettype none
`include "occupancy_grid_ray_update_core_macros.svh"
module ogru_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    operation,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire ogru_pkg::sts_t sts,
    output ogru_pkg::cmd_t     cmd
);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_CLEAR = 16'h0002,
        ST_WWR   = 16'h0004,
        ST_RD    = 16'h0008,
        ST_RDCAP = 16'h0010,
        ST_SIN1  = 16'h0020,
        ST_SIN2  = 16'h0040,
        ST_SIN3  = 16'h0080,
        ST_SIN4  = 16'h0100,
        ST_SIN5  = 16'h0200,
        ST_SIN6  = 16'h0400,
        ST_LOAD  = 16'h0800,
        ST_CHECK = 16'h1000,
        ST_WRITE = 16'h2000,
        ST_DIST  = 16'h4000,
        ST_DONE  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        cmd.mul_sel = ogru_pkg::MUL_UU;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    case (operation)
                        ogru_pkg::OP_WRITE: state_next = ST_WWR;
                        ogru_pkg::OP_BEAM:  state_next = ST_SIN1;
                        ogru_pkg::OP_READ:  state_next = ST_RD;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_WWR:
            begin
                cmd.world_we = 1'b1;
                state_next   = ST_DONE;
            end
            ST_RD:
            begin
                state_next = ST_RDCAP;
            end
            ST_RDCAP:
            begin
                cmd.cap_cval = 1'b1;
                state_next   = ST_DONE;
            end
            ST_SIN1:
            begin
                cmd.arg_hi  = pass_reg;
                cmd.mul_sel = ogru_pkg::MUL_UU;
                state_next  = ST_SIN2;
            end
            ST_SIN2:
            begin
                cmd.cap_t2  = 1'b1;
                cmd.mul_sel = ogru_pkg::MUL_CT2;
                state_next  = ST_SIN3;
            end
            ST_SIN3:
            begin
                cmd.mul_sel = ogru_pkg::MUL_BT2;
                state_next  = ST_SIN4;
            end
            ST_SIN4:
            begin
                cmd.arg_hi  = pass_reg;
                cmd.mul_sel = ogru_pkg::MUL_AU;
                state_next  = ST_SIN5;
            end
            ST_SIN5:
            begin
                cmd.mul_sel = ogru_pkg::MUL_SK;
                state_next  = ST_SIN6;
            end
            ST_SIN6:
            begin
                // second pass does the complementary angle, then squares the range
                if (pass_reg)
                begin
                    cmd.cap_db  = 1'b1;
                    cmd.mul_sel = ogru_pkg::MUL_RR;
                    pass_next   = 1'b0;
                    state_next  = ST_LOAD;
                end
                else
                begin
                    cmd.cap_da = 1'b1;
                    pass_next  = 1'b1;
                    state_next = ST_SIN1;
                end
            end
            ST_LOAD:
            begin
                cmd.load_ray = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.out_grid)
                begin
                    cmd.reason_we = 1'b1;
                    cmd.reason    = ogru_pkg::END_LEFT;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.rd_ray  = 1'b1;
                    cmd.set_end = 1'b1;
                    cmd.mul_sel = ogru_pkg::MUL_OX;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.occ_we  = 1'b1;
                cmd.cap_sq  = 1'b1;
                cmd.mul_sel = ogru_pkg::MUL_OY;
                if (sts.hit)
                begin
                    cmd.reason_we = 1'b1;
                    cmd.reason    = ogru_pkg::END_HIT;
                    state_next    = ST_DONE;
                end
                else
                    state_next = ST_DIST;
            end
            ST_DIST:
            begin
                if (sts.exceeded)
                begin
                    cmd.reason_we = 1'b1;
                    cmd.reason    = ogru_pkg::END_RANGE;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.step_ray = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OGRU_ASSERT_NEXT(a_take_leaves_idle, in_valid && in_ready, !in_ready)
    `OGRU_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid)
    `OGRU_ASSERT_NEXT(a_check_flow, state_reg == ST_CHECK, state_reg == ST_WRITE || state_reg == ST_DONE)
    `OGRU_ASSERT_IMP(a_no_take_in_clear, state_reg == ST_CLEAR, !in_ready && !cmd.take)

endmodule
`default_nettype wire

/* hw/rtl/ogru_dpath.sv */
// datapath: maps, configuration, sine and distance multiplier, beam position
`default_nettype none
module ogru_dpath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ogru_pkg::cmd_t             cmd,
    output ogru_pkg::sts_t                  sts,
    input  wire logic                       cfg_we,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [15:0]                cfg_data,
    input  wire logic [ogru_pkg::GX_BITS-1:0] cell_x,
    input  wire logic [ogru_pkg::GY_BITS-1:0] cell_y,
    input  wire logic                       world_value,
    input  wire logic [ogru_pkg::POS_W-1:0] start_x,
    input  wire logic [ogru_pkg::POS_W-1:0] start_y,
    input  wire logic [ogru_pkg::ANGLE_BITS-1:0] beam_angle,
    output logic signed [ogru_pkg::LOG_W-1:0] cell_value,
    output logic [1:0]                      end_reason,
    output logic [ogru_pkg::GX_BITS-1:0]    end_x,
    output logic [ogru_pkg::GY_BITS-1:0]    end_y
);

    localparam int CELLS = 2 ** ogru_pkg::ADDR_W;
    localparam int RW    = ogru_pkg::RAY_W;
    localparam int LW    = ogru_pkg::LOG_W;

    // configuration
    logic [9:0]  hit_reg;
    logic [10:0] pass_reg;
    logic [11:0] min_reg;
    logic [10:0] max_reg;
    logic [15:0] range_reg;

    // item
    logic [ogru_pkg::GX_BITS-1:0]    cx_reg;
    logic [ogru_pkg::GY_BITS-1:0]    cy_reg;
    logic                            wv_reg;
    logic [ogru_pkg::POS_W-1:0]      sx_reg, sy_reg;
    logic [ogru_pkg::ANGLE_BITS-3:0] tfrac_reg;
    logic [1:0]                      quad_reg;

    // results and output register
    logic [LW-1:0] cval_reg, out_cval_reg;
    logic [1:0]    reason_reg, out_reason_reg;
    logic [ogru_pkg::GX_BITS-1:0] ex_reg, out_ex_reg;
    logic [ogru_pkg::GY_BITS-1:0] ey_reg, out_ey_reg;

    // clearing pass
    logic [ogru_pkg::ADDR_W-1:0] clr_cnt_reg;

    // memories
    logic              world_mem [CELLS];
    logic [LW-1:0]     occ_mem   [CELLS];
    logic              world_rd_reg;
    logic [LW-1:0]     occ_rd_reg;
    logic [ogru_pkg::ADDR_W-1:0] rd_addr, item_addr, ray_addr, cur_addr_reg;
    logic [ogru_pkg::ADDR_W-1:0] occ_waddr, world_waddr;
    logic              occ_wen, world_wen, world_wdata;
    logic [LW-1:0]     occ_wdata;

    // multiplier and sine
    logic [ogru_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [ogru_pkg::PROD_W-1:0] prod_reg, sq_reg;
    logic [16:0] p_hi, t2_reg, u_arg, sat_s;
    logic [15:0] t_arg;
    logic [31:0] rnd;
    logic [ogru_pkg::STEP_W-1:0] da_reg, db_reg;
    logic [31:0] lim_reg;

    // beam position
    logic signed [RW-1:0] ray_reg, ray_next, sx_full, sy_full, ray_y_reg, ray_y_next;
    logic signed [RW-1:0] dx_ext, dy_ext, ox, oy;
    logic signed [ogru_pkg::STEP_W:0] dx, dy, pa, na, pb, nb;
    logic [ogru_pkg::MUL_W-1:0] ox_abs, oy_abs;
    logic [7:0] gx_int, gy_int;
    logic [44:0] dist_sum;
    logic [47:0] lim_full;

    // update
    logic signed [13:0] old_v, hit_v, pass_v, upd_v;

    assign t_arg = 16'({tfrac_reg, {ogru_pkg::T_SHIFT{1'b0}}});
    assign u_arg = cmd.arg_hi ? (ogru_pkg::Q16_ONE - {1'b0, t_arg}) : {1'b0, t_arg};
    assign p_hi  = prod_reg[32:16];
    assign sat_s = (p_hi > ogru_pkg::Q16_ONE) ? ogru_pkg::Q16_ONE : p_hi;
    assign rnd   = prod_reg[31:0] + 32'd32768;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            ogru_pkg::MUL_UU:
            begin
                mul_a = 22'(u_arg);
                mul_b = 22'(u_arg);
            end
            ogru_pkg::MUL_CT2:
            begin
                mul_a = 22'(ogru_pkg::POLY_C);
                mul_b = 22'(p_hi);
            end
            ogru_pkg::MUL_BT2:
            begin
                mul_a = 22'(17'(ogru_pkg::POLY_B - p_hi));
                mul_b = 22'(t2_reg);
            end
            ogru_pkg::MUL_AU:
            begin
                mul_a = 22'(17'(ogru_pkg::POLY_A - p_hi));
                mul_b = 22'(u_arg);
            end
            ogru_pkg::MUL_SK:
            begin
                mul_a = 22'(sat_s);
                mul_b = 22'(ogru_pkg::STEP_Q16);
            end
            ogru_pkg::MUL_OX:
            begin
                mul_a = ox_abs;
                mul_b = ox_abs;
            end
            ogru_pkg::MUL_OY:
            begin
                mul_a = oy_abs;
                mul_b = oy_abs;
            end
            ogru_pkg::MUL_RR:
            begin
                mul_a = 22'(range_reg);
                mul_b = 22'(range_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // step components from the quadrant
    assign pa = $signed({1'b0, da_reg});
    assign na = -pa;
    assign pb = $signed({1'b0, db_reg});
    assign nb = -pb;

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                dx = pb;
                dy = pa;
            end
            2'd1:
            begin
                dx = na;
                dy = pb;
            end
            2'd2:
            begin
                dx = nb;
                dy = na;
            end
            default:
            begin
                dx = pa;
                dy = nb;
            end
        endcase
    end

    assign dx_ext  = RW'(dx);
    assign dy_ext  = RW'(dy);
    assign sx_full = $signed({3'b000, sx_reg, 8'h00});
    assign sy_full = $signed({3'b000, sy_reg, 8'h00});

    always_comb
    begin
        ray_next   = ray_reg;
        ray_y_next = ray_y_reg;
        if (cmd.load_ray)
        begin
            ray_next   = sx_full + dx_ext;
            ray_y_next = sy_full + dy_ext;
        end
        else if (cmd.step_ray)
        begin
            ray_next   = ray_reg + dx_ext;
            ray_y_next = ray_y_reg + dy_ext;
        end
    end

    assign gx_int = ray_reg[23:16];
    assign gy_int = ray_y_reg[23:16];
    assign sts.out_grid = ray_reg[RW-1] || ray_y_reg[RW-1]
                       || (gx_int >= 8'(ogru_pkg::GRID_WIDTH))
                       || (gy_int >= 8'(ogru_pkg::GRID_HEIGHT));
    assign ray_addr  = {gy_int[ogru_pkg::GY_BITS-1:0], gx_int[ogru_pkg::GX_BITS-1:0]};
    assign item_addr = {cy_reg, cx_reg};

    // offsets stay inside the grid span here, so 22 bits of magnitude suffice
    assign ox     = ray_reg - sx_full;
    assign oy     = ray_y_reg - sy_full;
    assign ox_abs = ox[RW-1] ? 22'(-ox) : 22'(ox);
    assign oy_abs = oy[RW-1] ? 22'(-oy) : 22'(oy);

    assign dist_sum = {1'b0, sq_reg} + {1'b0, prod_reg};
    assign lim_full = {lim_reg, 16'h0000};
    assign sts.exceeded = {3'b000, dist_sum} > lim_full;

    assign sts.hit        = world_rd_reg;
    assign sts.clear_last = &clr_cnt_reg;

    // read-modify-write of the current cell
    always_comb
    begin
        old_v  = 14'(signed'(occ_rd_reg));
        hit_v  = old_v + $signed({4'b0000, hit_reg});
        pass_v = old_v + 14'(signed'(pass_reg));
        if (world_rd_reg)
        begin
            upd_v = hit_v;
            if (hit_v > $signed({3'b000, max_reg}))
                upd_v = $signed({3'b000, max_reg});
        end
        else
        begin
            upd_v = pass_v;
            if (pass_v < 14'(signed'(min_reg)))
                upd_v = 14'(signed'(min_reg));
        end
        if (upd_v > 14'sd2047)
            upd_v = 14'sd2047;
        else if (upd_v < -14'sd2048)
            upd_v = -14'sd2048;
    end

    assign rd_addr     = cmd.rd_ray ? ray_addr : item_addr;
    assign occ_wen     = cmd.clear || cmd.occ_we;
    assign occ_waddr   = cmd.clear ? clr_cnt_reg : cur_addr_reg;
    assign occ_wdata   = cmd.clear ? '0 : upd_v[LW-1:0];
    assign world_wen   = cmd.clear || cmd.world_we;
    assign world_waddr = cmd.clear ? clr_cnt_reg : item_addr;
    assign world_wdata = cmd.clear ? 1'b0 : wv_reg;

    always_ff @(posedge clk)
    begin
        if (occ_wen)
            occ_mem[occ_waddr] <= occ_wdata;
        occ_rd_reg <= occ_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (world_wen)
            world_mem[world_waddr] <= world_wdata;
        world_rd_reg <= world_mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        ray_reg   <= ray_next;
        ray_y_reg <= ray_y_next;
        if (cmd.cap_t2)
            t2_reg <= p_hi;
        if (cmd.cap_da)
            da_reg <= rnd[29:16];
        if (cmd.cap_db)
            db_reg <= rnd[29:16];
        if (cmd.load_ray)
            lim_reg <= prod_reg[31:0];
        if (cmd.cap_sq)
            sq_reg <= prod_reg;
        if (cmd.set_end)
            cur_addr_reg <= ray_addr;
        if (cmd.take)
        begin
            cx_reg    <= cell_x;
            cy_reg    <= cell_y;
            wv_reg    <= world_value;
            sx_reg    <= start_x;
            sy_reg    <= start_y;
            tfrac_reg <= beam_angle[ogru_pkg::ANGLE_BITS-3:0];
            quad_reg  <= beam_angle[ogru_pkg::ANGLE_BITS-1:ogru_pkg::ANGLE_BITS-2];
        end
        if (cmd.take)
        begin
            cval_reg   <= '0;
            reason_reg <= ogru_pkg::END_NONE;
            ex_reg     <= '0;
            ey_reg     <= '0;
        end
        else
        begin
            if (cmd.cap_cval)
                cval_reg <= occ_rd_reg;
            if (cmd.reason_we)
                reason_reg <= cmd.reason;
            if (cmd.set_end)
            begin
                ex_reg <= ray_addr[ogru_pkg::GX_BITS-1:0];
                ey_reg <= ray_addr[ogru_pkg::ADDR_W-1:ogru_pkg::GX_BITS];
            end
        end
        if (cmd.out_load)
        begin
            out_cval_reg   <= cval_reg;
            out_reason_reg <= reason_reg;
            out_ex_reg     <= ex_reg;
            out_ey_reg     <= ey_reg;
        end
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            hit_reg     <= ogru_pkg::HIT_RESET;
            pass_reg    <= ogru_pkg::PASS_RESET;
            min_reg     <= ogru_pkg::MIN_RESET;
            max_reg     <= ogru_pkg::MAX_RESET;
            range_reg   <= ogru_pkg::RANGE_RESET;
        end
        else
        begin
            if (cmd.clear)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ogru_pkg::CFG_HIT:   hit_reg   <= cfg_data[9:0];
                    ogru_pkg::CFG_PASS:  pass_reg  <= cfg_data[10:0];
                    ogru_pkg::CFG_MIN:   min_reg   <= cfg_data[11:0];
                    ogru_pkg::CFG_MAX:   max_reg   <= cfg_data[10:0];
                    ogru_pkg::CFG_RANGE: range_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    assign cell_value = $signed(out_cval_reg);
    assign end_reason = out_reason_reg;
    assign end_x      = out_ex_reg;
    assign end_y      = out_ey_reg;

endmodule
`default_nettype wire

/* hw/rtl/occupancy_grid_ray_update_core.sv */
// top level of the occupancy grid ray update core
//
//  channel | signals                                   | moves
//  in      | in_valid/in_ready + operation..beam_angle | one item: write, read or beam
//  out     | out_valid/out_ready + cell_value..end_y   | one result per item
//  cfg     | cfg_we, cfg_index, cfg_data               | one register write, no wait
//
// after reset a clearing pass walks both maps, one cell a cycle, and no item is taken until it ends
// write: take, map write, done; read: take, map read, capture, done; code 3: take, done
// a beam runs the sine set-up twice on the shared multiplier, loads the ray, then walks 0.2-cell steps
// (map read, read-modify-write, squared distance) through the check, write and distance states
// a finished result waits in the output register; the next item is taken meanwhile
`default_nettype none
module occupancy_grid_ray_update_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [5:0]  cell_x,
    input  wire logic [5:0]  cell_y,
    input  wire logic        world_value,
    input  wire logic [13:0] start_x,
    input  wire logic [13:0] start_y,
    input  wire logic [11:0] beam_angle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [11:0] cell_value,
    output logic [1:0]       end_reason,
    output logic [5:0]       end_x,
    output logic [5:0]       end_y,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    ogru_pkg::cmd_t cmd;
    ogru_pkg::sts_t sts;

    ogru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ogru_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .world_value (world_value),
        .start_x     (start_x),
        .start_y     (start_y),
        .beam_angle  (beam_angle),
        .cell_value  (cell_value),
        .end_reason  (end_reason),
        .end_x       (end_x),
        .end_y       (end_y)
    );

endmodule
`default_nettype wire

/* sim/ogru_checker.sv */
// checker for the occupancy grid ray update core: map predictor and result compare
`timescale 1ns / 1ps
module ogru_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [5:0]         cell_x,
    input  wire logic [5:0]         cell_y,
    input  wire logic               world_value,
    input  wire logic [13:0]        start_x,
    input  wire logic [13:0]        start_y,
    input  wire logic [11:0]        beam_angle,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [11:0] cell_value,
    input  wire logic [1:0]         end_reason,
    input  wire logic [5:0]         end_x,
    input  wire logic [5:0]         end_y,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic signed [11:0] cval;
        logic [1:0]         reason;
        logic [5:0]         ex;
        logic [5:0]         ey;
    } beam_result_t;

    logic               obstacle_map [ogru_pkg::GRID_WIDTH*ogru_pkg::GRID_HEIGHT];
    logic signed [11:0] log_odds_map [ogru_pkg::GRID_WIDTH*ogru_pkg::GRID_HEIGHT];
    int                 hit_inc;
    int                 pass_dec;
    int                 clamp_lo;
    int                 clamp_hi;
    longint             range_q8;
    beam_result_t       result_fifo [$];

    assign pending = result_fifo.size();

    function automatic longint quarter_sin(longint unsigned t);
        longint unsigned t2;
        longint unsigned s;
        t2 = (t * t) >> 16;
        s = (64'(ogru_pkg::POLY_C) * t2) >> 16;
        s = 64'(ogru_pkg::POLY_B) - s;
        s = (s * t2) >> 16;
        s = 64'(ogru_pkg::POLY_A) - s;
        s = (s * t) >> 16;
        if (s > 65536)
            s = 65536;
        return longint'(s);
    endfunction

    function automatic longint step_len(longint s, bit neg);
        longint d;
        d = (s * 64'(ogru_pkg::STEP_Q16) + 32768) >>> 16;
        return neg ? -d : d;
    endfunction

    function automatic logic signed [11:0] sat12(int v);
        if (v > 2047)
            v = 2047;
        if (v < -2048)
            v = -2048;
        return 12'(v);
    endfunction

    task automatic predict_item(output beam_result_t r);
        longint       sx;
        longint       sy;
        longint       rx;
        longint       ry;
        longint       dx;
        longint       dy;
        longint       sa;
        longint       sb;
        longint       lim;
        longint       ox;
        longint       oy;
        longint       tq;
        int           gx;
        int           gy;
        int           idx;
        int           v;
        logic [1:0]   quad;
        r = '0;
        if (operation == ogru_pkg::OP_WRITE)
        begin
            obstacle_map[{cell_y, cell_x}] = world_value;
        end
        else if (operation == ogru_pkg::OP_READ)
        begin
            r.cval = log_odds_map[{cell_y, cell_x}];
        end
        else if (operation == ogru_pkg::OP_BEAM)
        begin
            sx = longint'(start_x) << 8;
            sy = longint'(start_y) << 8;
            quad = beam_angle[11:10];
            tq = longint'(beam_angle[9:0]) << ogru_pkg::T_SHIFT;
            sa = quarter_sin(tq);
            sb = quarter_sin(65536 - tq);
            lim = (range_q8 * range_q8) << 16;
            case (quad)
                2'd0:
                begin
                    dy = step_len(sa, 0); dx = step_len(sb, 0);
                end
                2'd1:
                begin
                    dy = step_len(sb, 0); dx = step_len(sa, 1);
                end
                2'd2:
                begin
                    dy = step_len(sa, 1); dx = step_len(sb, 1);
                end
                default:
                begin
                    dy = step_len(sb, 1); dx = step_len(sa, 0);
                end
            endcase
            rx = sx;
            ry = sy;
            forever
            begin
                rx += dx;
                ry += dy;
                if (rx < 0 || ry < 0)
                begin
                    r.reason = ogru_pkg::END_LEFT;
                    break;
                end
                gx = int'(rx >>> 16);
                gy = int'(ry >>> 16);
                if (gx >= ogru_pkg::GRID_WIDTH || gy >= ogru_pkg::GRID_HEIGHT)
                begin
                    r.reason = ogru_pkg::END_LEFT;
                    break;
                end
                idx = gy * ogru_pkg::GRID_WIDTH + gx;
                r.ex = 6'(gx);
                r.ey = 6'(gy);
                if (obstacle_map[idx])
                begin
                    v = int'(log_odds_map[idx]) + hit_inc;
                    if (v > clamp_hi)
                        v = clamp_hi;
                    log_odds_map[idx] = sat12(v);
                    r.reason = ogru_pkg::END_HIT;
                    break;
                end
                v = int'(log_odds_map[idx]) + pass_dec;
                if (v < clamp_lo)
                    v = clamp_lo;
                log_odds_map[idx] = sat12(v);
                ox = rx - sx;
                oy = ry - sy;
                if (ox * ox + oy * oy > lim)
                begin
                    r.reason = ogru_pkg::END_RANGE;
                    break;
                end
            end
        end
    endtask

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beam_result_t got;
        beam_result_t want;
        if (!rst_n)
        begin
            foreach (obstacle_map[i])
            begin
                obstacle_map[i] = 1'b0;
                log_odds_map[i] = '0;
            end
            hit_inc  = int'(ogru_pkg::HIT_RESET);
            pass_dec = int'($signed(ogru_pkg::PASS_RESET));
            clamp_lo = int'($signed(ogru_pkg::MIN_RESET));
            clamp_hi = int'(ogru_pkg::MAX_RESET);
            range_q8 = longint'(ogru_pkg::RANGE_RESET);
            result_fifo.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ogru_pkg::CFG_HIT:   hit_inc  = int'(cfg_data[9:0]);
                    ogru_pkg::CFG_PASS:  pass_dec = int'($signed(cfg_data[10:0]));
                    ogru_pkg::CFG_MIN:   clamp_lo = int'($signed(cfg_data[11:0]));
                    ogru_pkg::CFG_MAX:   clamp_hi = int'(cfg_data[10:0]);
                    ogru_pkg::CFG_RANGE: range_q8 = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = '{cell_value, end_reason, end_x, end_y};
                if (result_fifo.size() == 0)
                    report("result with no item outstanding");
                else
                begin
                    want = result_fifo.pop_front();
                    if (got.cval !== want.cval)
                        report($sformatf("cell_value %0d, want %0d", got.cval, want.cval));
                    if (got.reason !== want.reason)
                        report($sformatf("end_reason %0d, want %0d", got.reason, want.reason));
                    if (got.ex !== want.ex)
                        report($sformatf("end_x %0d, want %0d", got.ex, want.ex));
                    if (got.ey !== want.ey)
                        report($sformatf("end_y %0d, want %0d", got.ey, want.ey));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_item(want);
                result_fifo.push_back(want);
            end
        end
    end

endmodule

/* sim/tb_top.sv */
// testbench top for the occupancy grid ray update core: stimulus and verdict
`timescale 1ns / 1ps
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         operation = '0;
    logic [5:0]         cell_x = '0;
    logic [5:0]         cell_y = '0;
    logic               world_value = 1'b0;
    logic [13:0]        start_x = '0;
    logic [13:0]        start_y = '0;
    logic [11:0]        beam_angle = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [11:0] cell_value;
    logic [1:0]         end_reason;
    logic [5:0]         end_x;
    logic [5:0]         end_y;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    int                 errors;
    int                 pending;

    bit                 no_idle = 0;
    bit                 hold_req = 0;
    int                 idle_cycles = 0;
    int                 n_beams = 0;
    int                 n_items = 0;
    int                 n_cfg = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    occupancy_grid_ray_update_core dut (.*);

    ogru_checker chk (.*);

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stall per item, one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_req = 0;
            end
            else if (!no_idle)
            begin
                n = $urandom_range(0, 4);
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send(logic [1:0] op, logic [5:0] x, logic [5:0] y, logic wv,
                        logic [13:0] sx, logic [13:0] sy, logic [11:0] ang);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        cell_x      <= x;
        cell_y      <= y;
        world_value <= wv;
        start_x     <= sx;
        start_y     <= sy;
        beam_angle  <= ang;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_items++;
        if (op == ogru_pkg::OP_BEAM)
            n_beams++;
    endtask

    task automatic send_random();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            send(ogru_pkg::OP_BEAM, 6'($urandom), 6'($urandom), 1'($urandom),
                 14'($urandom), 14'($urandom), 12'($urandom));
        else if (k < 70)
            // obstacles kept sparse so most beams walk a fair way
            send(ogru_pkg::OP_WRITE, 6'($urandom), 6'($urandom), ($urandom_range(0, 3) == 0),
                 14'($urandom), 14'($urandom), 12'($urandom));
        else if (k < 95)
            send(ogru_pkg::OP_READ, 6'($urandom), 6'($urandom), 1'($urandom),
                 14'($urandom), 14'($urandom), 12'($urandom));
        else
            send(ogru_pkg::OP_UNUSED, 6'($urandom), 6'($urandom), 1'($urandom),
                 14'($urandom), 14'($urandom), 12'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_regs(int hit, int pass, int lo, int hi, int range);
        in_valid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= ogru_pkg::CFG_HIT;   cfg_data <= 16'(hit);   @(posedge clk);
        cfg_index <= ogru_pkg::CFG_PASS;  cfg_data <= 16'(pass);  @(posedge clk);
        cfg_index <= ogru_pkg::CFG_MIN;   cfg_data <= 16'(lo);    @(posedge clk);
        cfg_index <= ogru_pkg::CFG_MAX;   cfg_data <= 16'(hi);    @(posedge clk);
        cfg_index <= ogru_pkg::CFG_RANGE; cfg_data <= 16'(range); @(posedge clk);
        cfg_we    <= 1'b0;
        n_cfg++;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings
        send(ogru_pkg::OP_READ, 6'd0, 6'd0, 1'b0, '0, '0, '0);
        send(ogru_pkg::OP_READ, 6'd63, 6'd63, 1'b0, '0, '0, '0);
        send(ogru_pkg::OP_UNUSED, 6'd63, 6'd63, 1'b1, 14'h3fff, 14'h3fff, 12'hfff);
        send(ogru_pkg::OP_WRITE, 6'd40, 6'd32, 1'b1, '0, '0, '0);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd8192, 14'd8320, 12'd0);
        send(ogru_pkg::OP_READ, 6'd40, 6'd32, 1'b0, '0, '0, '0);
        send(ogru_pkg::OP_READ, 6'd35, 6'd32, 1'b0, '0, '0, '0);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd8192, 14'd8192, 12'd1024);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd8192, 14'd8192, 12'd2048);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd8192, 14'd8192, 12'd3072);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd8192, 14'd8192, 12'd4095);
        // beam that leaves at once reports end cell zero
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd0, 14'd0, 12'd2048);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'h3fff, 14'h3fff, 12'd512);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd0, 14'd0, 12'd512);
        send(ogru_pkg::OP_WRITE, 6'd40, 6'd32, 1'b0, '0, '0, '0);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd8192, 14'd8320, 12'd0);
        send(ogru_pkg::OP_READ, 6'd45, 6'd32, 1'b0, '0, '0, '0);
        drain();

        // extremes: long range, full clamps
        set_regs(1023, -1023, -2048, 2047, 65535);
        send(ogru_pkg::OP_BEAM, '0, '0, 1'b0, 14'd128, 14'd128, 12'd512);
        send(ogru_pkg::OP_READ, 6'd10, 6'd10, 1'b0, '0, '0, '0);
        for (int i = 0; i < 100; i++)
        begin
            if (i == 20)
                hold_req = 1;
            send_random();
        end
        drain();

        // zero steps and zero range
        set_regs(0, 0, 0, 0, 0);
        for (int i = 0; i < 80; i++)
            send_random();
        // pause until the block has answered everything
        drain();
        no_idle = 1;
        for (int i = 0; i < 40; i++)
            send_random();
        no_idle = 0;
        drain();

        // random settings within range
        set_regs($urandom_range(0, 1023), -$urandom_range(0, 1023), -$urandom_range(0, 2048),
                 $urandom_range(0, 2047), $urandom_range(0, 65535));
        for (int i = 0; i < 120; i++)
            send_random();
        drain();

        // back to defaults, short range keeps beams brief
        set_regs(217, -217, -768, 768, $urandom_range(256, 4096));
        for (int i = 0; i < 140; i++)
            send_random();
        drain();

        repeat (50) @(posedge clk);
        $display("covered %0d items (%0d beams) over %0d register settings",
                 n_items, n_beams, n_cfg + 1);
        $display("register extremes, zero range, back-to-back and long result stall exercised");
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ogru_pkg.sv
hw/rtl/ogru_ctrl.sv
hw/rtl/ogru_dpath.sv
hw/rtl/occupancy_grid_ray_update_core.sv
sim/ogru_checker.sv
sim/tb_top.sv
